>>> hw/rtl/gbn_pkg.sv
// Shared types and constants for the go-back-n sender.
// No dependencies; imported by gbn_ctrl, gbn_dpath and go_back_n_sender.
`default_nettype none

package gbn_pkg;

   // Sequence space; must stay a power of two so wrap-around is plain truncation.
   localparam int SEQ_SPACE    = 8;
   localparam int SEQ_W        = $clog2(SEQ_SPACE);
   localparam int PAYLOAD_BITS = 64;
   localparam int WIN_W        = 3;
   localparam int TICKS_W      = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int SLOT_W       = 3;

   localparam logic [WIN_W-1:0]   WIN_RESET   = WIN_W'(4);
   localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(1000);
   localparam logic [WIN_W-1:0]   WIN_MAX     = WIN_W'(SEQ_SPACE - 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 1'b1;

   // Item kinds on the input side
   localparam logic [1:0] FUNC_SEND   = 2'd0;
   localparam logic [1:0] FUNC_ACK    = 2'd1;
   localparam logic [1:0] FUNC_EXPIRY = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_PACKET = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;
   localparam logic [1:0] KIND_STOP   = 2'd3;

   // Which result the datapath builds on an emit
   localparam logic [SLOT_W-1:0] SLOT_REPLY      = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_PKT_NEW    = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_START_SEQ  = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_STOP_SEQ   = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_START_BASE = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_STOP_TAG   = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_START_TAG  = 3'd6;
   localparam logic [SLOT_W-1:0] SLOT_RESEND     = 3'd7;

   typedef struct packed {
      logic [1:0]              func;
      logic [PAYLOAD_BITS-1:0] payload_word;
      logic [2:0]              ack_number;
      logic                    ack_checksum_ok;
      logic [2:0]              expired_seq;
   } req_item_type;

   typedef struct packed {
      logic [1:0]              out_kind;
      logic                    accepted;
      logic [2:0]              pkt_seq;
      logic [PAYLOAD_BITS-1:0] pkt_payload;
      logic [2:0]              timer_seq;
      logic [TICKS_W-1:0]      timer_ticks;
      logic                    window_full;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      logic              load;
      logic              decide;
      logic              emit;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       taken;      // combinational, meaningful during decide
      logic       accepted;   // registered outcome of the decide step
      logic       cnt_zero;   // window was empty at decide
      logic       restart;    // packets still outstanding after an ack
      logic       rem_zero;
      logic       rem_one;
      logic       out_free;
   } stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/gbn_dpath.sv
// Datapath of the go-back-n sender: window state, payload memory, config, result register.
// Depends on gbn_pkg; driven by gbn_ctrl through cmd_type / stat_type.
`default_nettype none

module gbn_dpath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire gbn_pkg::req_item_type        req_data,
   input  wire logic                         csr_we,
   input  wire logic [gbn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gbn_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire gbn_pkg::cmd_type             cmd,
   output gbn_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output gbn_pkg::rsp_item_type             rsp_data
);
   import gbn_pkg::*;

   logic [PAYLOAD_BITS-1:0] mem [SEQ_SPACE];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   req_item_type       item_ff;
   logic [SEQ_W-1:0]   base_ff, base_in;
   logic [SEQ_W-1:0]   next_ff, next_in;
   logic               full_ff, full_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [SEQ_W-1:0]   cnt_ff;
   logic               taken_ff;
   logic [SEQ_W-1:0]   ptr_ff, ptr_in;
   logic [SEQ_W-1:0]   rem_ff, rem_in;
   logic [WIN_W-1:0]   win_ff;
   logic [TICKS_W-1:0] ticks_ff;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_ff, res;

   logic [WIN_W-1:0]   w_eff;
   logic [SEQ_W-1:0]   cnt, ack, off;
   logic [SEQ_W:0]     cnt_p1;
   logic               send_ok, ack_ok, taken;

   // Window arithmetic; wrap-around comes from the SEQ_W-bit width
   always_comb begin
      w_eff = win_ff;
      if (win_ff == '0) begin
         w_eff = WIN_W'(1);
      end else if (win_ff > WIN_MAX) begin
         w_eff = WIN_MAX;
      end
      cnt     = next_ff - base_ff;
      cnt_p1  = {1'b0, cnt} + (SEQ_W+1)'(1);
      ack     = item_ff.ack_number[SEQ_W-1:0];
      off     = ack - base_ff;
      send_ok = !full_ff && ((SEQ_W+1)'(cnt) < (SEQ_W+1)'(w_eff));
      ack_ok  = item_ff.ack_checksum_ok && ((SEQ_W+1)'(off) < (SEQ_W+1)'(w_eff))
                && (off < cnt);
      case (item_ff.func)
         FUNC_SEND: taken = send_ok;
         FUNC_ACK:  taken = ack_ok;
         default:   taken = 1'b0;
      endcase
   end

   always_comb begin
      base_in = base_ff;
      next_in = next_ff;
      full_in = full_ff;
      seq_in  = seq_ff;
      ptr_in  = ptr_ff;
      rem_in  = rem_ff;
      if (cmd.decide) begin
         case (item_ff.func)
            FUNC_SEND: begin
               if (send_ok) begin
                  seq_in  = next_ff;
                  next_in = next_ff + SEQ_W'(1);
                  full_in = (cnt_p1 >= (SEQ_W+1)'(w_eff));
               end
            end
            FUNC_ACK: begin
               if (ack_ok) begin
                  seq_in  = base_ff;
                  base_in = ack + SEQ_W'(1);
                  full_in = 1'b0;
               end
            end
            FUNC_EXPIRY: begin
               ptr_in = base_ff;
               rem_in = cnt;
            end
            default: begin
            end
         endcase
      end else if (cmd.emit && cmd.slot == SLOT_RESEND) begin
         ptr_in = ptr_ff + SEQ_W'(1);
         rem_in = rem_ff - SEQ_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         next_ff  <= '0;
         full_ff  <= 1'b0;
         win_ff   <= WIN_RESET;
         ticks_ff <= TICKS_RESET;
         rem_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff <= base_in;
         next_ff <= next_in;
         full_ff <= full_in;
         rem_ff  <= rem_in;
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_SIZE: win_ff   <= csr_wdata[WIN_W-1:0];
               CSR_TIMEOUT:     ticks_ff <= csr_wdata[TICKS_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.decide) begin
         cnt_ff   <= cnt;
         taken_ff <= taken;
      end
      seq_ff <= seq_in;
      ptr_ff <= ptr_in;
      if (cmd.emit) begin
         rsp_ff <= res;
      end
   end

   // Payload buffer: written on a taken send, read at the resend pointer
   always_ff @(posedge clock) begin
      if (cmd.decide && item_ff.func == FUNC_SEND && send_ok) begin
         mem[next_ff] <= item_ff.payload_word;
      end
      rd_data_ff <= mem[ptr_ff];
   end

   always_comb begin
      res             = '0;
      res.window_full = full_ff;
      res.last        = cmd.last;
      case (cmd.slot)
         SLOT_REPLY: begin
            res.out_kind = KIND_REPLY;
            res.accepted = taken_ff;
         end
         SLOT_PKT_NEW: begin
            res.out_kind    = KIND_PACKET;
            res.pkt_seq     = seq_ff;
            res.pkt_payload = item_ff.payload_word;
         end
         SLOT_START_SEQ: begin
            res.out_kind    = KIND_START;
            res.timer_seq   = seq_ff;
            res.timer_ticks = ticks_ff;
         end
         SLOT_STOP_SEQ: begin
            res.out_kind  = KIND_STOP;
            res.timer_seq = seq_ff;
         end
         SLOT_START_BASE: begin
            res.out_kind    = KIND_START;
            res.timer_seq   = base_ff;
            res.timer_ticks = ticks_ff;
         end
         SLOT_STOP_TAG: begin
            res.out_kind  = KIND_STOP;
            res.timer_seq = item_ff.expired_seq;
         end
         SLOT_START_TAG: begin
            res.out_kind    = KIND_START;
            res.timer_seq   = item_ff.expired_seq;
            res.timer_ticks = ticks_ff;
         end
         SLOT_RESEND: begin
            res.out_kind    = KIND_PACKET;
            res.pkt_seq     = ptr_ff;
            res.pkt_payload = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stat.func     = item_ff.func;
      stat.taken    = taken;
      stat.accepted = taken_ff;
      stat.cnt_zero = (cnt_ff == '0);
      stat.restart  = (base_ff != next_ff);
      stat.rem_zero = (rem_ff == '0);
      stat.rem_one  = (rem_ff == SEQ_W'(1));
      stat.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gbn_ctrl.sv
// Controller of the go-back-n sender: sequences the decide step and each result transfer.
// Depends on gbn_pkg; talks to gbn_dpath only through cmd_type / stat_type.
`default_nettype none

module gbn_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire gbn_pkg::stat_type stat,
   output gbn_pkg::cmd_type       cmd
);
   import gbn_pkg::*;

   localparam logic [3:0] S_IDLE        = 4'd0;
   localparam logic [3:0] S_DECIDE      = 4'd1;
   localparam logic [3:0] S_REPLY       = 4'd2;
   localparam logic [3:0] S_PKT         = 4'd3;
   localparam logic [3:0] S_START_NEW   = 4'd4;
   localparam logic [3:0] S_STOP_OLD    = 4'd5;
   localparam logic [3:0] S_START_BASE  = 4'd6;
   localparam logic [3:0] S_STOP_TAG    = 4'd7;
   localparam logic [3:0] S_START_TAG   = 4'd8;
   localparam logic [3:0] S_READ        = 4'd9;
   localparam logic [3:0] S_RESEND      = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.slot   = SLOT_REPLY;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            case (stat.func)
               FUNC_SEND:   state_in = S_REPLY;
               FUNC_ACK:    state_in = stat.taken ? S_STOP_OLD : S_IDLE;
               FUNC_EXPIRY: state_in = S_STOP_TAG;
               default:     state_in = S_IDLE;
            endcase
         end
         S_REPLY: begin
            cmd.slot = SLOT_REPLY;
            cmd.last = !stat.accepted;
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               state_in = stat.accepted ? S_PKT : S_IDLE;
            end
         end
         S_PKT: begin
            cmd.slot = SLOT_PKT_NEW;
            cmd.last = !stat.cnt_zero;
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               state_in = stat.cnt_zero ? S_START_NEW : S_IDLE;
            end
         end
         S_START_NEW: begin
            cmd.slot = SLOT_START_SEQ;
            cmd.last = 1'b1;
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_STOP_OLD: begin
            cmd.slot = SLOT_STOP_SEQ;
            cmd.last = !stat.restart;
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               state_in = stat.restart ? S_START_BASE : S_IDLE;
            end
         end
         S_START_BASE: begin
            cmd.slot = SLOT_START_BASE;
            cmd.last = 1'b1;
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_STOP_TAG: begin
            cmd.slot = SLOT_STOP_TAG;
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               state_in = S_START_TAG;
            end
         end
         S_START_TAG: begin
            cmd.slot = SLOT_START_TAG;
            cmd.last = stat.rem_zero;
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               state_in = stat.rem_zero ? S_IDLE : S_READ;
            end
         end
         S_READ: begin
            // memory read of the resend pointer lands this cycle
            state_in = S_RESEND;
         end
         S_RESEND: begin
            cmd.slot = SLOT_RESEND;
            cmd.last = stat.rem_one;
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               state_in = stat.rem_one ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/go_back_n_sender.sv
// Go-back-n ARQ sender window: top level joining controller and datapath.
// The first result is registered after the decide state, then an emit state.
// Requests are taken one item at a time: decide, then one emit state per result;
//   an expiry also passes a read state before each resent packet (one payload memory read),
//   and every emit state waits while the result side stalls.
// Reset (synchronous, active high): window empty, base/next 0, window_size 4,
//   timeout_ticks 1000; payload memory is not cleared.
`default_nettype none

module go_back_n_sender (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire gbn_pkg::req_item_type          req_data,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output gbn_pkg::rsp_item_type               rsp_data,
   // configuration writes
   input  wire logic                           csr_we,
   input  wire logic [gbn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gbn_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gbn_pkg::*;

   cmd_type  cmd;   // controller -> datapath
   stat_type stat;  // datapath -> controller

   // Sequencer: a request transfer is taken only in idle; each result
   // transfer is issued when the output register is free or draining.
   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Window state, payload buffer and the single output register.
   gbn_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
